FILE: design/lspa_pkg.sv
// shared types, constants and color helpers of the led strip pattern animator
`default_nettype none

package lspa_pkg;

	localparam int STRIP_PIXELS_DEF = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] MODE_NONE    = 3'd0;
	localparam logic [2:0] MODE_RAINBOW = 3'd1;
	localparam logic [2:0] MODE_CHASE   = 3'd2;
	localparam logic [2:0] MODE_WIPE    = 3'd3;
	localparam logic [2:0] MODE_SCANNER = 3'd4;
	localparam logic [2:0] MODE_FADE    = 3'd5;

	localparam logic [2:0] REG_PATTERN_MODE = 3'd0;
	localparam logic [2:0] REG_INTERVAL_MS  = 3'd1;
	localparam logic [2:0] REG_COLOR_ONE    = 3'd2;
	localparam logic [2:0] REG_COLOR_TWO    = 3'd3;
	localparam logic [2:0] REG_FADE_STEPS   = 3'd4;
	localparam logic [2:0] REG_REVERSE      = 3'd5;
	localparam logic [2:0] REG_PIXEL_COUNT  = 3'd6;
	localparam logic [2:0] REG_FIRST_PIXEL  = 3'd7;

	localparam logic [4:0] DIV_LAST = 5'd23;

	typedef struct packed {
		logic [2:0]  pattern_mode;
		logic [7:0]  interval_ms;
		logic [23:0] color_one;
		logic [23:0] color_two;
		logic [15:0] fade_steps;
		logic        reverse;
		logic [5:0]  pixel_count;
		logic [5:0]  first_pixel;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] idx;
		logic [15:0] total;
		logic        done;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FADE_MUL,
		BK_FADE_DIV,
		BK_PIX,
		BK_SCAN_RD,
		BK_SCAN_WR
	} bk_state_t;

	function automatic logic [23:0] wheel(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] p3;
		p = 8'd255 - pos;
		if (p < 8'd85) begin
			p3 = p + p + p;
			wheel = {8'd255 - p3, 8'd0, p3};
		end else if (p < 8'd170) begin
			p = p - 8'd85;
			p3 = p + p + p;
			wheel = {8'd0, p3, 8'd255 - p3};
		end else begin
			p = p - 8'd170;
			p3 = p + p + p;
			wheel = {p3, 8'd255 - p3, 8'd0};
		end
	endfunction

	function automatic logic [23:0] dim_color(input logic [23:0] c);
		dim_color = {1'b0, c[23:17], 1'b0, c[15:9], 1'b0, c[7:1]};
	endfunction

	// base four digits, each worth one modulo three
	function automatic logic [1:0] mod3_16(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
			+ 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		mod3_16 = t[1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/led_strip_pattern_animator.sv
// top level of the led strip pattern animator: config registers, front, queue, back
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall   | now_ms
// out     | out | out_valid / out_stall | pixel_address, pixel_color, last_write, cycle_done
// cfg     | in  | cfg_write             | cfg_index, cfg_data
//
// a tick is classified combinationally; due frames queue up, two deep
// rainbow, chase, wipe: one beat per cycle unless out_stall holds; scanner: store read state, then write state
// fade: per channel multiply and 24 step divide before its beats
// async reset; the pixel store reads as zero until written, through per pixel valid bits
// out_stall holds the output register and the back end; ticks still queue until full
`default_nettype none

module led_strip_pattern_animator import lspa_pkg::*; #(
	parameter int STRIP_PIXELS = STRIP_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       pixel_address,
	output logic [23:0]      pixel_color,
	output logic             last_write,
	output logic             cycle_done
);

	cfg_t cfg_q;
	logic mode_clear;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t pop_job;

	assign mode_clear = cfg_write && (cfg_index == REG_PATTERN_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pattern_mode: MODE_NONE, interval_ms: 8'd0, color_one: 24'd0,
				color_two: 24'd0, fade_steps: 16'd1, reverse: 1'b0,
				pixel_count: 6'd1, first_pixel: 6'd0};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_MODE: cfg_q.pattern_mode <= cfg_data[2:0];
				REG_INTERVAL_MS:  cfg_q.interval_ms  <= cfg_data[7:0];
				REG_COLOR_ONE:    cfg_q.color_one    <= cfg_data;
				REG_COLOR_TWO:    cfg_q.color_two    <= cfg_data;
				REG_FADE_STEPS:   cfg_q.fade_steps   <= cfg_data[15:0];
				REG_REVERSE:      cfg_q.reverse      <= cfg_data[0];
				REG_PIXEL_COUNT:  cfg_q.pixel_count  <= cfg_data[5:0];
				REG_FIRST_PIXEL:  cfg_q.first_pixel  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	lspa_front #(
		.STRIP_PIXELS(STRIP_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.mode_clear (mode_clear),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	lspa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	lspa_back #(
		.STRIP_PIXELS(STRIP_PIXELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_job         (pop_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last_write    (last_write),
		.cycle_done    (cycle_done)
	);

endmodule

`default_nettype wire

FILE: design/lspa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lspa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/lspa_front.sv
// front end: frame timing, step index and job classification
`default_nettype none

module lspa_front import lspa_pkg::*; #(
	parameter int STRIP_PIXELS = STRIP_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        mode_clear,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic        q_full,
	output logic             push,
	output job_t             job
);

	localparam logic [15:0] SCAN_TOTAL = 16'((STRIP_PIXELS - 1) * 2);

	logic [31:0] last_q;
	logic [15:0] step_q;
	logic [31:0] elapsed;
	logic        due;
	logic        active;
	logic        accept;
	logic [15:0] total_raw;
	logic [15:0] total;
	logic [16:0] fwd;
	logic [15:0] step_d;
	logic        done;

	assign elapsed  = now_ms - last_q;
	assign due      = elapsed > {24'd0, cfg.interval_ms};
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && due && active;
	assign fwd      = {1'b0, step_q} + 17'd1;

	always_comb begin
		active = 1'b1;
		unique case (cfg.pattern_mode)
			MODE_RAINBOW: total_raw = 16'd255;
			MODE_CHASE,
			MODE_WIPE: total_raw = {10'd0, cfg.pixel_count};
			MODE_SCANNER: total_raw = SCAN_TOTAL;
			MODE_FADE: total_raw = cfg.fade_steps;
			default: begin
				total_raw = 16'd1;
				active = 1'b0;
			end
		endcase
		total = (total_raw == 16'd0) ? 16'd1 : total_raw;
		if (!cfg.reverse) begin
			if (fwd >= {1'b0, total}) begin
				step_d = 16'd0;
				done = 1'b1;
			end else begin
				step_d = fwd[15:0];
				done = 1'b0;
			end
		end else begin
			if (step_q <= 16'd1) begin
				step_d = total - 16'd1;
				done = 1'b1;
			end else begin
				step_d = step_q - 16'd1;
				done = 1'b0;
			end
		end
		job = '{mode: cfg.pattern_mode, idx: step_q, total: total, done: done};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			step_q <= '0;
		end else begin
			if (mode_clear) begin
				step_q <= '0;
			end else if (push) begin
				step_q <= step_d;
			end
			if (accept && due) begin
				last_q <= now_ms;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/lspa_queue.sv
// short job queue between front and back
`default_nettype none

module lspa_queue import lspa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      pop_job,
	output logic      empty
);

	job_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full    = cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/lspa_back.sv
// back end: fade divider, pixel sequencer, pixel store and output register
`default_nettype none

module lspa_back import lspa_pkg::*; #(
	parameter int STRIP_PIXELS = STRIP_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_empty,
	input  wire job_t        q_job,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       pixel_address,
	output logic [23:0]      pixel_color,
	output logic             last_write,
	output logic             cycle_done
);

	localparam int AW = $clog2(STRIP_PIXELS);
	localparam logic [7:0] QSTEP = 8'(256 / STRIP_PIXELS);
	localparam logic [7:0] RSTEP = 8'(256 % STRIP_PIXELS);
	localparam logic [7:0] STRIP8 = 8'(STRIP_PIXELS);

	bk_state_t         state_q, state_d;
	job_t              job_q;
	logic [6:0]        i_q;
	logic [1:0]        m_q;
	logic [7:0]        q_q;
	logic [7:0]        r_q;
	logic [1:0]        ch_q;
	logic [23:0]       num_q;
	logic [15:0]       rem_q;
	logic [4:0]        cnt_q;
	logic [23:0]       fade_col_q;
	logic [STRIP_PIXELS-1:0] vld_q;
	logic              rd_vld_q;
	logic [23:0]       rd_data;

	logic [15:0] base;
	logic [6:0]  count;
	logic [16:0] addr_w;
	logic        in_range;
	logic        is_last;
	logic [23:0] color;
	logic [17:0] mirror;
	logic        hit;
	logic        out_free;
	logic        emit;
	logic        advance;
	logic [15:0] e_idx;
	logic [15:0] t_minus_e;
	logic [7:0]  ch_a;
	logic [7:0]  ch_b;
	logic [23:0] prod_a;
	logic [23:0] prod_b;
	logic [16:0] trial;
	logic        qbit;
	logic [7:0]  r_sum;

	assign out_free = !out_valid || !out_stall;
	assign addr_w   = {1'b0, base} + {10'd0, i_q};
	assign in_range = (i_q < count) && (addr_w < 17'(STRIP_PIXELS));
	assign is_last  = ((i_q + 7'd1) == count) || (addr_w == 17'(STRIP_PIXELS - 1));
	assign mirror   = {2'b0, job_q.total} - {2'b0, job_q.idx};
	assign hit      = ({9'd0, i_q} == job_q.idx) || ({11'd0, i_q} == mirror);
	assign e_idx    = (job_q.idx > job_q.total) ? job_q.total : job_q.idx;
	assign t_minus_e = job_q.total - e_idx;
	assign prod_a   = {16'd0, ch_a} * {8'd0, t_minus_e};
	assign prod_b   = {16'd0, ch_b} * {8'd0, e_idx};
	assign trial    = {rem_q, num_q[23]};
	assign qbit     = trial >= {1'b0, job_q.total};
	assign r_sum    = r_q + RSTEP;

	always_comb begin
		unique case (ch_q)
			2'd0: begin
				ch_a = cfg.color_one[23:16];
				ch_b = cfg.color_two[23:16];
			end
			2'd1: begin
				ch_a = cfg.color_one[15:8];
				ch_b = cfg.color_two[15:8];
			end
			default: begin
				ch_a = cfg.color_one[7:0];
				ch_b = cfg.color_two[7:0];
			end
		endcase
	end

	always_comb begin
		unique case (job_q.mode)
			MODE_WIPE: begin
				base  = job_q.idx;
				count = 7'd1;
				color = cfg.color_one;
			end
			MODE_SCANNER: begin
				base  = {10'd0, cfg.pixel_count};
				count = {1'b0, cfg.pixel_count};
				color = hit ? cfg.color_one : (rd_vld_q ? dim_color(rd_data) : 24'd0);
			end
			MODE_FADE: begin
				base  = {10'd0, cfg.first_pixel};
				count = {1'b0, cfg.pixel_count};
				color = fade_col_q;
			end
			MODE_CHASE: begin
				base  = 16'd0;
				count = 7'(STRIP_PIXELS);
				color = (m_q == 2'd0) ? cfg.color_one : cfg.color_two;
			end
			default: begin
				base  = 16'd0;
				count = {1'b0, cfg.pixel_count};
				color = wheel(q_q + job_q.idx[7:0]);
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		advance = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_job.mode == MODE_FADE) begin
						state_d = BK_FADE_MUL;
					end else if (q_job.mode == MODE_SCANNER) begin
						state_d = BK_SCAN_RD;
					end else begin
						state_d = BK_PIX;
					end
				end
			end
			BK_FADE_MUL: state_d = BK_FADE_DIV;
			BK_FADE_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = (ch_q == 2'd2) ? BK_PIX : BK_FADE_MUL;
				end
			end
			BK_PIX: begin
				if (!in_range) begin
					state_d = BK_IDLE;
				end else if (out_free) begin
					emit = 1'b1;
					if (is_last) begin
						state_d = BK_IDLE;
					end else begin
						advance = 1'b1;
					end
				end
			end
			BK_SCAN_RD: state_d = in_range ? BK_SCAN_WR : BK_IDLE;
			BK_SCAN_WR: begin
				if (out_free) begin
					emit = 1'b1;
					if (is_last) begin
						state_d = BK_IDLE;
					end else begin
						advance = 1'b1;
						state_d = BK_SCAN_RD;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				vld_q[addr_w[AW-1:0]] <= 1'b1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[i_q[AW-1:0]];
		if (emit) begin
			pixel_address <= addr_w[5:0];
			pixel_color   <= color;
			last_write    <= is_last;
			cycle_done    <= job_q.done;
		end
		if (pop) begin
			job_q <= q_job;
			i_q   <= '0;
			m_q   <= mod3_16(q_job.idx);
			q_q   <= '0;
			r_q   <= '0;
			ch_q  <= '0;
		end else if (advance) begin
			i_q <= i_q + 7'd1;
			m_q <= (m_q == 2'd2) ? 2'd0 : m_q + 2'd1;
			if (r_sum >= STRIP8) begin
				r_q <= r_sum - STRIP8;
				q_q <= q_q + QSTEP + 8'd1;
			end else begin
				r_q <= r_sum;
				q_q <= q_q + QSTEP;
			end
		end
		if (state_q == BK_FADE_MUL) begin
			num_q <= prod_a + prod_b;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == BK_FADE_DIV) begin
			rem_q <= qbit ? 16'(trial - {1'b0, job_q.total}) : trial[15:0];
			num_q <= {num_q[22:0], qbit};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == DIV_LAST) begin
				unique case (ch_q)
					2'd0: fade_col_q[23:16] <= {num_q[6:0], qbit};
					2'd1: fade_col_q[15:8]  <= {num_q[6:0], qbit};
					default: fade_col_q[7:0] <= {num_q[6:0], qbit};
				endcase
				ch_q <= ch_q + 2'd1;
			end
		end
	end

	lspa_ram #(
		.WIDTH(24),
		.DEPTH(STRIP_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (emit),
		.waddr (addr_w[AW-1:0]),
		.wdata (color),
		.raddr (i_q[AW-1:0]),
		.rdata (rd_data)
	);

	a_emit_on_strip: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> addr_w < 17'(STRIP_PIXELS))
		else $error("pixel write beyond strip");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FADE_DIV && cnt_q < 5'd16) |-> !qbit)
		else $error("fade quotient exceeds a byte");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_FADE_DIV |-> rem_q < job_q.total)
		else $error("divider remainder out of range");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN_WR |-> in_range)
		else $error("scanner write without a pixel");

endmodule

`default_nettype wire
